// File: rtl/tumf_pkg.sv
// ----------------------------------------------------------------------------
// Tagged byte-stream multiplexer package
// Shared framing constants and the job descriptor that passes from the
// classifying front end, through the job queue, to the byte serializer.
// ----------------------------------------------------------------------------
package tumf_pkg;

    localparam logic [7:0] ESC_BYTE    = 8'hFF;
    localparam logic [7:0] RESET_CODE  = 8'hFD;
    localparam logic [7:0] MARKER_LEAD = 8'h00;

    localparam int COUNT_LSB = 24;
    localparam int COUNT_W   = 2;
    localparam int DATA_W    = 24;

    // One classified input transaction. A job always produces at least one byte.
    typedef struct packed {
        logic               marker;  // emit the reset marker 00 FF FD
        logic               hdr;     // emit escape byte and tag first
        logic [7:0]         tag;
        logic [COUNT_W-1:0] count;   // payload bytes, 0 to 3
        logic [DATA_W-1:0]  data;
    } job_t;

endpackage

// File: rtl/tumf_front.sv
// ----------------------------------------------------------------------------
// Front end
// Accepts input transactions, tracks the selected client and turns each
// transaction into a job descriptor. Transactions that produce no bytes are
// consumed without a job.
// ----------------------------------------------------------------------------
module tumf_front
    import tumf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [7:0]  s_client_tag,
    input  logic [31:0] s_message_word,
    output logic        push,
    output job_t        push_job,
    input  logic        q_ready
);

    logic [7:0]         cur_tag_reg, cur_tag_next;
    logic               tag_valid_reg, tag_valid_next;
    logic               accept;
    logic               need_hdr;
    logic [COUNT_W-1:0] count;

    assign s_ready  = q_ready;
    assign accept   = s_valid && q_ready;
    assign count    = s_message_word[COUNT_LSB +: COUNT_W];
    assign need_hdr = !tag_valid_reg || (cur_tag_reg != s_client_tag);

    always_comb begin
        push_job.marker = s_mode;
        push_job.hdr    = !s_mode && need_hdr;
        push_job.tag    = s_client_tag;
        push_job.count  = count;
        push_job.data   = s_message_word[DATA_W-1:0];
        push            = accept && (s_mode || need_hdr || (count != '0));

        cur_tag_next   = cur_tag_reg;
        tag_valid_next = tag_valid_reg;
        if (accept) begin
            if (s_mode) begin
                tag_valid_next = 1'b0;
            end else begin
                cur_tag_next   = s_client_tag;
                tag_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_tag_reg   <= '0;
            tag_valid_reg <= 1'b0;
        end else begin
            cur_tag_reg   <= cur_tag_next;
            tag_valid_reg <= tag_valid_next;
        end
    end

endmodule

// File: rtl/tumf_queue.sv
// ----------------------------------------------------------------------------
// Job queue
// Small register FIFO between the front end and the serializer.
// ----------------------------------------------------------------------------
module tumf_queue
    import tumf_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic q_ready,
    output logic q_valid,
    output job_t q_job,
    input  logic pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign q_ready = (count_reg != CW'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_job   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg != CW'(DEPTH)))
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (count_reg != '0))
        else $error("job queue read while empty");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("job queue fill count out of range");
`endif

endmodule

// File: rtl/tumf_back.sv
// ----------------------------------------------------------------------------
// Byte serializer
// Emits the bytes of queued jobs one per cycle, unless m_ready stalls, via an
// output register: header, payload with escape doubling, or reset marker.
// ----------------------------------------------------------------------------
module tumf_back
    import tumf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    input  job_t       q_job,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_last_of_run
);

    typedef enum logic [2:0] {
        PH_HDR_ESC,
        PH_HDR_TAG,
        PH_DATA,
        PH_DUP,
        PH_MK0,
        PH_MK1,
        PH_MK2
    } phase_t;

    phase_t             phase_reg, phase_next, phase_adv, phase_init;
    logic [COUNT_W-1:0] idx_reg, idx_next, idx_adv;
    logic               busy_reg, busy_next;
    job_t               job_reg, job_next;
    logic               m_valid_reg, m_valid_next;
    logic [7:0]         m_byte_reg, m_byte_next;
    logic               m_last_reg, m_last_next;

    logic               emit;
    logic               done;
    logic               idx_last;
    logic [7:0]         cur_byte;
    logic [7:0]         data_byte;

    assign emit      = busy_reg && (!m_valid_reg || m_ready);
    assign pop       = q_valid && (!busy_reg || (emit && done));
    assign data_byte = job_reg.data[{idx_reg, 3'b000} +: 8];
    assign idx_last  = (idx_reg == job_reg.count - 1'b1);

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = m_byte_reg;
    assign m_last_of_run = m_last_reg;

    // Byte of the current step and where the sequencer goes after it.
    always_comb begin
        cur_byte  = ESC_BYTE;
        done      = 1'b0;
        phase_adv = phase_reg;
        idx_adv   = idx_reg;
        case (phase_reg)
            PH_HDR_ESC: begin
                phase_adv = PH_HDR_TAG;
            end
            PH_HDR_TAG: begin
                cur_byte  = job_reg.tag;
                done      = (job_reg.count == '0);
                phase_adv = PH_DATA;
                idx_adv   = '0;
            end
            PH_DATA: begin
                cur_byte = data_byte;
                if (data_byte == ESC_BYTE) begin
                    phase_adv = PH_DUP;
                end else begin
                    done    = idx_last;
                    idx_adv = idx_reg + 1'b1;
                end
            end
            PH_DUP: begin
                done      = idx_last;
                phase_adv = PH_DATA;
                idx_adv   = idx_reg + 1'b1;
            end
            PH_MK0: begin
                cur_byte  = MARKER_LEAD;
                phase_adv = PH_MK1;
            end
            PH_MK1: begin
                phase_adv = PH_MK2;
            end
            PH_MK2: begin
                cur_byte = RESET_CODE;
                done     = 1'b1;
            end
            default: begin
                done = 1'b1;
            end
        endcase

        if (q_job.marker) begin
            phase_init = PH_MK0;
        end else if (q_job.hdr) begin
            phase_init = PH_HDR_ESC;
        end else begin
            phase_init = PH_DATA;
        end
    end

    always_comb begin
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        busy_next    = busy_reg;
        job_next     = job_reg;
        m_valid_next = m_valid_reg;
        m_byte_next  = m_byte_reg;
        m_last_next  = m_last_reg;

        if (emit) begin
            m_valid_next = 1'b1;
            m_byte_next  = cur_byte;
            m_last_next  = done;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (pop) begin
            job_next   = q_job;
            busy_next  = 1'b1;
            phase_next = phase_init;
            idx_next   = '0;
        end else if (emit) begin
            if (done) begin
                busy_next = 1'b0;
            end else begin
                phase_next = phase_adv;
                idx_next   = idx_adv;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_MK0;
            idx_reg     <= '0;
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            idx_reg     <= idx_next;
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
        job_reg    <= job_next;
        m_byte_reg <= m_byte_next;
        m_last_reg <= m_last_next;
    end

`ifndef SYNTHESIS
    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && (phase_reg == PH_DATA || phase_reg == PH_DUP))
            |-> (idx_reg < job_reg.count))
        else $error("payload index beyond byte count");

    a_dup_follows_esc: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && phase_reg == PH_DUP) |-> (data_byte == ESC_BYTE))
        else $error("escape doubling without an escape byte");

    a_pop_only_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && busy_reg) |-> (emit && done))
        else $error("job loaded while previous job unfinished");
`endif

endmodule

// File: rtl/tagged_uart_mux_framer_core.sv
// ----------------------------------------------------------------------------
// Tagged byte-stream multiplexer, top level
// Frames client message words onto one shared byte stream with escape-byte
// client switching and a reset marker.
// ----------------------------------------------------------------------------
// Each input transaction is either a client message word (mode 0) carrying up
// to three payload bytes, or a reset marker request (mode 1). For a message
// whose client differs from the last one selected, the block first sends the
// escape byte 0xFF and the client tag; it then sends the payload bytes from
// the low byte up, doubling every 0xFF. A reset marker sends 00 FF FD and
// deselects the client. Every output transaction carries one byte, and
// last_of_run marks the final byte caused by an input transaction. The input
// side takes one transaction per cycle while the job queue has room; the
// serializer sends one byte per cycle while the receiver is ready, and an
// input transaction produces 0 to 8 bytes; one that produces no byte leaves
// no job for the serializer. Sustained rate is therefore set by the
// serializer's single byte lane.
module tagged_uart_mux_framer_core
    import tumf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [7:0]  s_client_tag,
    input  logic [31:0] s_message_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last_of_run
);

    // Front end to queue.
    logic push;
    job_t push_job;
    logic q_ready;

    // Queue to serializer.
    logic q_valid;
    job_t q_job;
    logic pop;

    // The front end classifies each transaction against the selected client
    // and queues a job; its state updates at acceptance, so job order in the
    // queue matches input order.
    tumf_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_client_tag   (s_client_tag),
        .s_message_word (s_message_word),
        .push           (push),
        .push_job       (push_job),
        .q_ready        (q_ready)
    );

    // The queue lets the front end keep accepting while the serializer is
    // stalled by the downstream transmitter.
    tumf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .q_ready  (q_ready),
        .q_valid  (q_valid),
        .q_job    (q_job),
        .pop      (pop)
    );

    // The serializer loads the next job in the same cycle that the previous
    // one sends its last byte, so bytes flow without gaps.
    tumf_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_job         (q_job),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run)
    );

endmodule

// File: test/tagged_uart_mux_framer_core_tb.sv
// ----------------------------------------------------------------------------
// Tagged byte-stream multiplexer testbench
// Drives message words and reset marker requests into the framer and checks
// every byte it sends against a built-in framing predictor. A directed
// section covers each framing rule. Random traffic then runs under several
// sender and receiver idling phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tagged_uart_mux_framer_core_tb;
    import tumf_pkg::*;

    localparam logic MODE_MESSAGE = 1'b0;
    localparam logic MODE_MARKER  = 1'b1;

    localparam int RESET_CYCLES  = 5;
    localparam int DRAIN_CYCLES  = 40;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int REPORT_LIMIT  = 10;
    localparam int PHASE_ITEMS   = 112;

    // One byte on the shared stream, with its end-of-run flag.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } framed_byte_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_mode;
    logic [7:0]  s_client_tag;
    logic [31:0] s_message_word;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_out_byte;
    logic        m_last_of_run;

    // Predictor state: which client the stream currently belongs to.
    logic [7:0]   sel_tag;
    logic         sel_valid;
    framed_byte_t expected_bytes[$];
    framed_byte_t head;

    int src_idle_pct;
    int sink_stall_pct;
    int mismatch_count;
    int cycle_count;

    tagged_uart_mux_framer_core u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_client_tag   (s_client_tag),
        .s_message_word (s_message_word),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_last_of_run  (m_last_of_run)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Works out the bytes that one accepted transaction produces and queues
    // them. The switch header goes out when no client is selected or the tag
    // changes; a header tag of 0xFF is never doubled, payload 0xFF always is.
    function automatic void predict_frame(input logic mode, input logic [7:0] tag,
                                          input logic [31:0] word);
        framed_byte_t  run[$];
        framed_byte_t  tail;
        logic [7:0]    payload;
        int            count;

        if (mode == MODE_MARKER) begin
            run.push_back('{MARKER_LEAD, 1'b0});
            run.push_back('{ESC_BYTE, 1'b0});
            run.push_back('{RESET_CODE, 1'b0});
            // The marker deselects the client but leaves the tag register alone.
            sel_valid = 1'b0;
        end else begin
            count = int'(word[COUNT_LSB +: COUNT_W]);
            if (!sel_valid || sel_tag != tag) begin
                run.push_back('{ESC_BYTE, 1'b0});
                run.push_back('{tag, 1'b0});
                sel_tag   = tag;
                sel_valid = 1'b1;
            end
            for (int i = 0; i < count; i++) begin
                payload = word[8*i +: 8];
                run.push_back('{payload, 1'b0});
                if (payload == ESC_BYTE) begin
                    run.push_back('{ESC_BYTE, 1'b0});
                end
            end
        end

        // A repeat of the selected client with no payload yields nothing.
        if (run.size() > 0) begin
            tail      = run.pop_back();
            tail.last = 1'b1;
            run.push_back(tail);
        end
        foreach (run[i]) begin
            expected_bytes.push_back(run[i]);
        end
    endfunction

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        end
    endtask

    // Presents one transaction and holds it until the framer takes it. Must be
    // entered right after a rising edge. Idle cycles before the transaction
    // keep valid low; once raised, valid stays up until the handshake.
    task automatic send_word(input logic mode, input logic [7:0] tag,
                             input logic [31:0] word);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_mode         <= mode;
        s_client_tag   <= tag;
        s_message_word <= word;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        // The transaction was taken at this edge; its bytes can only follow.
        predict_frame(mode, tag, word);
    endtask

    // Receiver: stalls at random per the current phase and checks every byte
    // it takes against the oldest expectation.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
            if (m_valid && m_ready) begin
                if (expected_bytes.size() == 0) begin
                    note_mismatch($sformatf("unexpected byte %02h last %0b",
                                            m_out_byte, m_last_of_run));
                end else begin
                    head = expected_bytes.pop_front();
                    if (m_out_byte !== head.data || m_last_of_run !== head.last) begin
                        note_mismatch($sformatf(
                            "expected byte %02h last %0b, got byte %02h last %0b",
                            head.data, head.last, m_out_byte, m_last_of_run));
                    end
                end
            end
        end
    end

    // Reset marker handling: the marker deselects the client, so even the
    // same tag must be announced again, and back-to-back markers stand alone.
    task automatic test_marker_and_reselect();
        send_word(MODE_MARKER, 8'h3C, 32'h0312_3456);
        send_word(MODE_MESSAGE, 8'h00, 32'h0100_0042);
        send_word(MODE_MARKER, 8'hFF, 32'hFFFF_FFFF);
        send_word(MODE_MARKER, 8'h00, 32'h0000_0000);
        send_word(MODE_MESSAGE, 8'h00, 32'h0000_0000);
        send_word(MODE_MESSAGE, 8'h00, 32'h0000_0000);
    endtask

    // Escape doubling: a tag of 0xFF is sent once, payload 0xFF twice. The
    // all-ones word gives the longest run of eight bytes.
    task automatic test_escape_doubling();
        send_word(MODE_MESSAGE, 8'hFF, 32'hFFFF_FFFF);
        send_word(MODE_MESSAGE, 8'hFF, 32'h02FF_00FF);
        send_word(MODE_MESSAGE, 8'hA5, 32'h01FF_FFFF);
        send_word(MODE_MESSAGE, 8'hA5, 32'h0380_FF7F);
    endtask

    // Byte count field: unused payload bytes and the top six bits are
    // ignored, and a zero count to a new client sends the header alone.
    task automatic test_count_field();
        send_word(MODE_MESSAGE, 8'h5A, 32'hFC12_3456);
        send_word(MODE_MESSAGE, 8'h5A, 32'hFDAB_CD01);
        send_word(MODE_MESSAGE, 8'h5A, 32'h02FF_0201);
        send_word(MODE_MESSAGE, 8'h5A, 32'hFF00_0000);
        send_word(MODE_MESSAGE, 8'h01, 32'h0000_0000);
        send_word(MODE_MESSAGE, 8'h80, 32'h0301_0000);
        send_word(MODE_MESSAGE, 8'h7F, 32'h0300_0000);
    endtask

    // Random traffic under one idling setting. Most words come from a small
    // set of clients so that runs without a header are common; payload bytes
    // are often forced to 0xFF to exercise doubling.
    task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                       input int n_items);
        logic [7:0]  tag_pool[4];
        logic        mode;
        logic [7:0]  tag;
        logic [31:0] word;

        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        tag_pool[0]    = 8'h00;
        tag_pool[1]    = ESC_BYTE;
        tag_pool[2]    = 8'($urandom_range(0, 255));
        tag_pool[3]    = 8'($urandom_range(0, 255));
        for (int n = 0; n < n_items; n++) begin
            mode = ($urandom_range(0, 99) < 8) ? MODE_MARKER : MODE_MESSAGE;
            if ($urandom_range(0, 99) < 75) begin
                tag = tag_pool[$urandom_range(0, 3)];
            end else begin
                tag = 8'($urandom_range(0, 255));
            end
            word = $urandom();
            for (int k = 0; k < 3; k++) begin
                if ($urandom_range(0, 3) == 0) begin
                    word[8*k +: 8] = ESC_BYTE;
                end
            end
            send_word(mode, tag, word);
        end
    endtask

    // Watchdog: ends a run that hangs.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tagged_uart_mux_framer_core verification failed");
        $finish;
    end

    initial begin
        aclk           = 1'b0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_mode         = MODE_MESSAGE;
        s_client_tag   = 8'h00;
        s_message_word = 32'h0000_0000;
        sel_tag        = 8'h00;
        sel_valid      = 1'b0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        mismatch_count = 0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        test_marker_and_reselect();
        test_escape_doubling();
        test_count_field();

        test_random_traffic(0, 0, PHASE_ITEMS);
        test_random_traffic(84, 0, PHASE_ITEMS);
        test_random_traffic(0, 84, PHASE_ITEMS);
        test_random_traffic(24, 24, PHASE_ITEMS);
        s_valid <= 1'b0;

        // Let every queued byte arrive, then watch a while for strays.
        while (expected_bytes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("tagged_uart_mux_framer_core verification clean");
        end else begin
            $display("tagged_uart_mux_framer_core verification failed");
        end
        $finish;
    end

endmodule
